[rtl/bcmi_pkg.sv]
// ============================================================================
// bcmi_pkg: shared definitions for the bit/class mutual information core
// Operation and status codes, fixed field widths and the structs that link
// the sequencer to the shared log/multiply unit.
// ============================================================================
package bcmi_pkg;

   localparam int OP_W    = 2;
   localparam int LABEL_W = 16;
   localparam int INDEX_W = 11;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 20;
   localparam int MI_W    = 36;

   // Operand width of the shared unit: holds a count sum of up to 33 bits.
   localparam int TERM_W  = 33;
   localparam int PROD_W  = 64;
   localparam int ACC_W   = 66;
   localparam int MANT_W  = 32;
   localparam int EXP_W   = 6;

   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_SET   = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_THIRD  = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_REC = 2'd2;
   localparam logic [STAT_W-1:0] ST_NEG    = 2'd3;

   localparam int TERM_CNT_W = 4;
   localparam logic [TERM_CNT_W-1:0] LAST_TERM = 4'd8;

   typedef struct packed {
      logic              start;
      logic [TERM_W-1:0] arg;
      logic [TERM_W-1:0] mult;
   } term_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } term_rsp_type;

endpackage

[rtl/bcmi_if.sv]
// ============================================================================
// bcmi_req_if / bcmi_rsp_if: request and response channels
// Valid/ready channels carrying the request and response payloads.
// ============================================================================
interface bcmi_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcmi_pkg::OP_W-1:0]     operation;
   logic [bcmi_pkg::LABEL_W-1:0]  class_label;
   logic [bcmi_pkg::INDEX_W-1:0]  bit_index;

   modport source (output valid, operation, class_label, bit_index, input ready);
   modport sink   (input valid, operation, class_label, bit_index, output ready);
endinterface

interface bcmi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bcmi_pkg::STAT_W-1:0]   status;
   logic                          bit_seen;
   logic [bcmi_pkg::CNT_W-1:0]    hits_a;
   logic [bcmi_pkg::CNT_W-1:0]    hits_b;
   logic [bcmi_pkg::CNT_W-1:0]    misses_a;
   logic [bcmi_pkg::CNT_W-1:0]    misses_b;
   logic [bcmi_pkg::MI_W-1:0]     mutual_info;

   modport source (output valid, status, bit_seen, hits_a, hits_b, misses_a, misses_b,
                   mutual_info, input ready);
   modport sink   (input valid, status, bit_seen, hits_a, hits_b, misses_a, misses_b,
                   mutual_info, output ready);
endinterface

[rtl/bcmi_term_unit.sv]
// ============================================================================
// bcmi_term_unit: shared n * log2(x) unit
// One multiplier serves the repeated squarings of the log2 mantissa and the
// final product with n.
// ============================================================================
module bcmi_term_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bcmi_pkg::term_req_type term_req,
   output bcmi_pkg::term_rsp_type term_rsp
);

   localparam int TW = bcmi_pkg::TERM_W;
   localparam int CW = $clog2(FRAC_BITS + 1);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_SQ   = 2'd1;
   localparam logic [1:0] T_MUL  = 2'd2;
   localparam logic [1:0] T_DONE = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [bcmi_pkg::MANT_W-1:0]   mant_ff, mant_in;
   logic [bcmi_pkg::EXP_W-1:0]    exp_ff, exp_in;
   logic [FRAC_BITS-1:0]          frac_ff, frac_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [TW-1:0]                 n_ff, n_in;
   logic [bcmi_pkg::PROD_W-1:0]   prod_ff, prod_in;

   logic [TW-1:0]                 mul_a, mul_b;
   logic [2*TW-1:0]               mul_p;
   logic [bcmi_pkg::EXP_W-1:0]    lead;
   logic [63:0]                   norm;
   logic [32:0]                   sq;

   assign mul_p = mul_a * mul_b;
   assign sq    = mul_p[63:31];

   // Position of the top set bit; zero input gives zero, which yields log 0.
   always_comb begin
      lead = '0;
      for (int i = 0; i < TW; i++) begin
         if (term_req.arg[i]) begin
            lead = bcmi_pkg::EXP_W'(i);
         end
      end
      norm = {term_req.arg[31:0], 32'd0} >> 1;
      norm = (64'(term_req.arg) << 31) >> lead;
   end

   always_comb begin
      state_in = state_ff;
      mant_in  = mant_ff;
      exp_in   = exp_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      prod_in  = prod_ff;
      mul_a    = {1'b0, mant_ff};
      mul_b    = {1'b0, mant_ff};
      case (state_ff)
         T_IDLE: begin
            if (term_req.start) begin
               mant_in  = norm[31:0];
               exp_in   = lead;
               frac_in  = '0;
               cnt_in   = CW'(FRAC_BITS);
               n_in     = term_req.mult;
               state_in = T_SQ;
            end
         end
         T_SQ: begin
            if (sq[32]) begin
               mant_in = sq[32:1];
            end else begin
               mant_in = sq[31:0];
            end
            frac_in = {frac_ff[FRAC_BITS-2:0], sq[32]};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = T_MUL;
            end
         end
         T_MUL: begin
            mul_a    = n_ff;
            mul_b    = TW'({exp_ff, frac_ff});
            prod_in  = mul_p[bcmi_pkg::PROD_W-1:0];
            state_in = T_DONE;
         end
         T_DONE: begin
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mant_ff <= mant_in;
      exp_ff  <= exp_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      prod_ff <= prod_in;
   end

   assign term_rsp.done    = (state_ff == T_DONE);
   assign term_rsp.product = prod_ff;

endmodule

[rtl/bit_class_mutual_information_core.sv]
// ============================================================================
// bit_class_mutual_information_core: per-bit mutual information scorer
// Counts per-class hits of fingerprint bits and scores a queried bit by the
// mutual information between the bit and a two-class label.
// ============================================================================
//
//   channel    direction  handshake          payload
//   req_chan   in         valid / ready      operation, class_label, bit_index
//   rsp_chan   out        valid / ready      status, bit_seen, hits_a, hits_b,
//                                            misses_a, misses_b, mutual_info
//
// After reset the hit counter memory is cleared, one entry per cycle, so no
// request is taken until the clear is done. A start-record request answers in
// the next cycle; a set-bit request answers after the read-modify-write of the
// counter memory in S_SET. In a query, nine n*log2(x) terms run one after
// another through the shared multiplier, each needing FRAC_BITS squarings. One
// request is in work at a time; a new one is taken only once the response has
// been delivered.
module bit_class_mutual_information_core #(
   parameter int NUM_BITS    = 2048,
   parameter int COUNT_WIDTH = 20,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   bcmi_req_if.sink           req_chan,
   bcmi_rsp_if.source         rsp_chan
);

   localparam int AW  = $clog2(NUM_BITS);
   localparam int CW  = COUNT_WIDTH;
   localparam int TW  = bcmi_pkg::TERM_W;
   localparam int AC  = bcmi_pkg::ACC_W;
   localparam int TOL = (1 << FRAC_BITS) / 100;
   localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic signed [AC-1:0] NEG_TOL = -AC'(TOL);
   localparam logic [AC-1:0] MI_MAX = AC'({bcmi_pkg::MI_W{1'b1}});

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SET    = 3'd2;
   localparam logic [2:0] S_QLOAD  = 3'd3;
   localparam logic [2:0] S_QSTART = 3'd4;
   localparam logic [2:0] S_QWAIT  = 3'd5;
   localparam logic [2:0] S_QFIN   = 3'd6;

   logic [2:0]                    state_ff, state_in;
   logic [AW-1:0]                 clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]                 addr_ff, addr_in;

   // Class bookkeeping.
   logic [bcmi_pkg::LABEL_W-1:0]  a_label_ff, a_label_in, b_label_ff, b_label_in;
   logic                          a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic [CW-1:0]                 na_ff, na_in, nb_ff, nb_in, total_ff, total_in;
   logic                          is_b_ff, is_b_in, open_ff, open_in;

   // Query working registers.
   logic [CW-1:0]                 ha_ff, ha_in, hb_ff, hb_in, ma_ff, ma_in, mb_ff, mb_in;
   logic [CW:0]                   h_ff, h_in, m_ff, m_in;
   logic [bcmi_pkg::TERM_CNT_W-1:0] k_ff, k_in;
   logic signed [AC-1:0]          acc_ff, acc_in;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bcmi_pkg::STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                          rsp_seen_ff, rsp_seen_in;
   logic [bcmi_pkg::CNT_W-1:0]    rsp_ha_ff, rsp_ha_in, rsp_hb_ff, rsp_hb_in;
   logic [bcmi_pkg::CNT_W-1:0]    rsp_ma_ff, rsp_ma_in, rsp_mb_ff, rsp_mb_in;
   logic [bcmi_pkg::MI_W-1:0]     rsp_mi_ff, rsp_mi_in;

   // Hit counter memory: class B count in the upper half, class A below.
   logic [2*CW-1:0]               mem [NUM_BITS];
   logic [2*CW-1:0]               rd_q;
   logic                          mem_we, mem_re;
   logic [AW-1:0]                 mem_wa;
   logic [2*CW-1:0]               mem_wd;

   bcmi_pkg::term_req_type        term_req;
   bcmi_pkg::term_rsp_type        term_rsp;

   logic                          accept;
   logic [31:0]                   idx32;
   logic                          in_range;
   logic [AW-1:0]                 req_addr;
   logic [TW-1:0]                 term_n, term_x;
   logic                          term_plus;
   logic [AC-1:0]                 mi_wide;

   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept   = req_chan.valid && req_chan.ready;
   assign idx32    = 32'(req_chan.bit_index);
   assign in_range = idx32 < NUM_BITS;
   assign req_addr = idx32[AW-1:0];
   assign mem_re   = accept;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_q <= mem[req_addr];
      end
   end

   // Term k of the sum: plus (na+nb)*L(total), minus F(na), F(nb), F(h), F(m),
   // plus F(ha), F(hb), F(ma), F(mb).
   always_comb begin
      term_n    = TW'(na_ff);
      term_x    = TW'(na_ff);
      term_plus = 1'b0;
      case (k_ff)
         4'd0: begin
            term_n    = TW'({1'b0, na_ff} + {1'b0, nb_ff});
            term_x    = TW'(total_ff);
            term_plus = 1'b1;
         end
         4'd1: begin
            term_n = TW'(na_ff);
            term_x = TW'(na_ff);
         end
         4'd2: begin
            term_n = TW'(nb_ff);
            term_x = TW'(nb_ff);
         end
         4'd3: begin
            term_n = TW'(h_ff);
            term_x = TW'(h_ff);
         end
         4'd4: begin
            term_n = TW'(m_ff);
            term_x = TW'(m_ff);
         end
         4'd5: begin
            term_n    = TW'(ha_ff);
            term_x    = TW'(ha_ff);
            term_plus = 1'b1;
         end
         4'd6: begin
            term_n    = TW'(hb_ff);
            term_x    = TW'(hb_ff);
            term_plus = 1'b1;
         end
         4'd7: begin
            term_n    = TW'(ma_ff);
            term_x    = TW'(ma_ff);
            term_plus = 1'b1;
         end
         default: begin
            term_n    = TW'(mb_ff);
            term_x    = TW'(mb_ff);
            term_plus = 1'b1;
         end
      endcase
   end

   assign term_req.start = (state_ff == S_QSTART);
   assign term_req.arg   = term_x;
   assign term_req.mult  = term_n;

   bcmi_term_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_term (
      .clock    (clock),
      .reset    (reset),
      .term_req (term_req),
      .term_rsp (term_rsp)
   );

   // Scale the positive sum to 16 fraction bits and saturate to the field.
   assign mi_wide = AC'($unsigned(acc_ff)) >> SHR;

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      addr_in       = addr_ff;
      a_label_in    = a_label_ff;
      b_label_in    = b_label_ff;
      a_valid_in    = a_valid_ff;
      b_valid_in    = b_valid_ff;
      na_in         = na_ff;
      nb_in         = nb_ff;
      total_in      = total_ff;
      is_b_in       = is_b_ff;
      open_in       = open_ff;
      ha_in         = ha_ff;
      hb_in         = hb_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      h_in          = h_ff;
      m_in          = m_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_seen_in   = rsp_seen_ff;
      rsp_ha_in     = rsp_ha_ff;
      rsp_hb_in     = rsp_hb_ff;
      rsp_ma_in     = rsp_ma_ff;
      rsp_mb_in     = rsp_mb_ff;
      rsp_mi_in     = rsp_mi_ff;
      mem_we        = 1'b0;
      mem_wa        = addr_ff;
      mem_wd        = rd_q;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(NUM_BITS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               // Most requests answer with zero fields; a query fills them later.
               rsp_status_in = bcmi_pkg::ST_OK;
               rsp_seen_in   = 1'b0;
               rsp_ha_in     = '0;
               rsp_hb_in     = '0;
               rsp_ma_in     = '0;
               rsp_mb_in     = '0;
               rsp_mi_in     = '0;
               rsp_valid_in  = 1'b1;
               case (req_chan.operation)
                  bcmi_pkg::OP_START: begin
                     if (a_valid_ff && req_chan.class_label == a_label_ff) begin
                        is_b_in = 1'b0;
                     end else if (b_valid_ff && req_chan.class_label == b_label_ff) begin
                        is_b_in = 1'b1;
                     end else if (!a_valid_ff) begin
                        a_valid_in = 1'b1;
                        a_label_in = req_chan.class_label;
                        is_b_in    = 1'b0;
                     end else if (!b_valid_ff) begin
                        b_valid_in = 1'b1;
                        b_label_in = req_chan.class_label;
                        is_b_in    = 1'b1;
                     end else begin
                        rsp_status_in = bcmi_pkg::ST_THIRD;
                     end
                     if (rsp_status_in == bcmi_pkg::ST_THIRD) begin
                        open_in = 1'b0;
                     end else begin
                        if (is_b_in) begin
                           if (nb_ff != '1) nb_in = nb_ff + 1'b1;
                        end else begin
                           if (na_ff != '1) na_in = na_ff + 1'b1;
                        end
                        if (total_ff != '1) total_in = total_ff + 1'b1;
                        open_in = 1'b1;
                     end
                  end
                  bcmi_pkg::OP_SET: begin
                     if (!open_ff) begin
                        rsp_status_in = bcmi_pkg::ST_NO_REC;
                     end else if (in_range) begin
                        rsp_valid_in = 1'b0;
                        addr_in      = req_addr;
                        state_in     = S_SET;
                     end
                  end
                  bcmi_pkg::OP_QUERY: begin
                     if (in_range && total_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        addr_in      = req_addr;
                        state_in     = S_QLOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SET: begin
            // A class counter never passes its class record count.
            mem_we = 1'b1;
            if (is_b_ff) begin
               if (rd_q[2*CW-1:CW] < nb_ff) begin
                  mem_wd[2*CW-1:CW] = rd_q[2*CW-1:CW] + 1'b1;
               end
            end else begin
               if (rd_q[CW-1:0] < na_ff) begin
                  mem_wd[CW-1:0] = rd_q[CW-1:0] + 1'b1;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_QLOAD: begin
            ha_in    = rd_q[CW-1:0];
            hb_in    = rd_q[2*CW-1:CW];
            ma_in    = na_ff - rd_q[CW-1:0];
            mb_in    = nb_ff - rd_q[2*CW-1:CW];
            h_in     = {1'b0, rd_q[CW-1:0]} + {1'b0, rd_q[2*CW-1:CW]};
            m_in     = {1'b0, na_ff - rd_q[CW-1:0]} + {1'b0, nb_ff - rd_q[2*CW-1:CW]};
            k_in     = '0;
            acc_in   = '0;
            state_in = S_QSTART;
         end
         S_QSTART: begin
            state_in = S_QWAIT;
         end
         S_QWAIT: begin
            if (term_rsp.done) begin
               if (term_plus) begin
                  acc_in = acc_ff + $signed(AC'(term_rsp.product));
               end else begin
                  acc_in = acc_ff - $signed(AC'(term_rsp.product));
               end
               if (k_ff == bcmi_pkg::LAST_TERM) begin
                  state_in = S_QFIN;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_QSTART;
               end
            end
         end
         S_QFIN: begin
            rsp_seen_in = (h_ff != '0);
            rsp_ha_in   = bcmi_pkg::CNT_W'(ha_ff);
            rsp_hb_in   = bcmi_pkg::CNT_W'(hb_ff);
            rsp_ma_in   = bcmi_pkg::CNT_W'(ma_ff);
            rsp_mb_in   = bcmi_pkg::CNT_W'(mb_ff);
            if (acc_ff < 0) begin
               // Rounding can leave a slightly negative sum; only a clear
               // negative is reported.
               rsp_mi_in     = '0;
               rsp_status_in = (acc_ff < NEG_TOL) ? bcmi_pkg::ST_NEG : bcmi_pkg::ST_OK;
            end else begin
               rsp_status_in = bcmi_pkg::ST_OK;
               if (mi_wide > (MI_MAX >> SHL)) begin
                  rsp_mi_in = '1;
               end else begin
                  rsp_mi_in = bcmi_pkg::MI_W'(mi_wide << SHL);
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         a_label_ff   <= '0;
         b_label_ff   <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         na_ff        <= '0;
         nb_ff        <= '0;
         total_ff     <= '0;
         is_b_ff      <= 1'b0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         a_label_ff   <= a_label_in;
         b_label_ff   <= b_label_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         total_ff     <= total_in;
         is_b_ff      <= is_b_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      ha_ff         <= ha_in;
      hb_ff         <= hb_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      h_ff          <= h_in;
      m_ff          <= m_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seen_ff   <= rsp_seen_in;
      rsp_ha_ff     <= rsp_ha_in;
      rsp_hb_ff     <= rsp_hb_in;
      rsp_ma_ff     <= rsp_ma_in;
      rsp_mb_ff     <= rsp_mb_in;
      rsp_mi_ff     <= rsp_mi_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.bit_seen    = rsp_seen_ff;
   assign rsp_chan.hits_a      = rsp_ha_ff;
   assign rsp_chan.hits_b      = rsp_hb_ff;
   assign rsp_chan.misses_a    = rsp_ma_ff;
   assign rsp_chan.misses_b    = rsp_mb_ff;
   assign rsp_chan.mutual_info = rsp_mi_ff;

endmodule

[rtl/bcmi_checker.sv]
// ============================================================================
// bcmi_checker: port-level checks for the mutual information core
// Watches the request and response ports over time.
// ============================================================================
module bcmi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bcmi_pkg::STAT_W-1:0]   rsp_status,
   input logic [bcmi_pkg::CNT_W-1:0]    rsp_hits_a,
   input logic [bcmi_pkg::MI_W-1:0]     rsp_mutual_info
);

   // The counter memory is being cleared right after reset.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during counter clear");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bcmi_pkg::ST_THIRD || rsp_status == bcmi_pkg::ST_NO_REC
                    || rsp_status == bcmi_pkg::ST_NEG)
      |-> rsp_mutual_info == '0)
      else $error("rejected request carries information");

   a_reject_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bcmi_pkg::ST_THIRD || rsp_status == bcmi_pkg::ST_NO_REC)
      |-> rsp_hits_a == '0)
      else $error("rejected request carries counts");

endmodule

bind bit_class_mutual_information_core bcmi_checker u_bcmi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_hits_a      (rsp_chan.hits_a),
   .rsp_mutual_info (rsp_chan.mutual_info)
);

[tb/bit_class_mutual_information_core_tb.sv]
// ============================================================================
// bit_class_mutual_information_core_tb: self-checking bench for the MI core
// Sends record, set-bit and query requests, predicts every response from a
// behavioral copy of the counters and the fixed-point log, and compares each
// response field by field with random stalls on both channels.
// ============================================================================
module bit_class_mutual_information_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NUM_BITS   = 2048;
   localparam int  FRAC       = 16;
   localparam int  N_RANDOM   = 1500;
   localparam int  CYCLE_CAP  = 2000000;
   localparam int  DRAIN      = 300;
   localparam logic [bcmi_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam longint CNT_MAX = (64'd1 << bcmi_pkg::CNT_W) - 1;
   localparam longint MI_MAX  = (64'd1 << bcmi_pkg::MI_W) - 1;

   typedef struct packed {
      logic [bcmi_pkg::OP_W-1:0]    operation;
      logic [bcmi_pkg::LABEL_W-1:0] class_label;
      logic [bcmi_pkg::INDEX_W-1:0] bit_index;
   } request_type;

   typedef struct packed {
      logic [bcmi_pkg::STAT_W-1:0] status;
      logic                        bit_seen;
      logic [bcmi_pkg::CNT_W-1:0]  hits_a;
      logic [bcmi_pkg::CNT_W-1:0]  hits_b;
      logic [bcmi_pkg::CNT_W-1:0]  misses_a;
      logic [bcmi_pkg::CNT_W-1:0]  misses_b;
      logic [bcmi_pkg::MI_W-1:0]   mutual_info;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcmi_req_if req_chan ();
   bcmi_rsp_if rsp_chan ();

   bit_class_mutual_information_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #1 clock = ~clock;

   // Shadow copy of the block's class bookkeeping and hit counters.
   logic [bcmi_pkg::LABEL_W-1:0] label_a, label_b;
   logic               have_a, have_b, open_is_b, rec_open;
   longint             recs_a, recs_b, recs_total;
   longint             hits_a_mem [NUM_BITS];
   longint             hits_b_mem [NUM_BITS];

   request_type pending_requests [$];
   score_type   expected_scores [$];
   int          failures = 0;
   int          responses_seen = 0;

   // Fixed-point log2 with FRAC fraction bits, by repeated mantissa squaring.
   function automatic longint unsigned log2_fixed(longint unsigned x);
      int              top;
      longint unsigned mant, res;
      if (x == 0) return 0;
      top = 63;
      while (x[top] == 1'b0) top--;
      mant = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
      res  = longint'(top) << FRAC;
      for (int i = FRAC; i > 0; i--) begin
         mant = (mant * mant) >> 31;
         if (mant >= (64'd1 << 32)) begin
            mant = mant >> 1;
            res  = res | (64'd1 << (i - 1));
         end
      end
      return res;
   endfunction

   function automatic longint n_log_n(longint unsigned n);
      return longint'(n * log2_fixed(n));
   endfunction

   function automatic longint add_clamped(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'h8000_0000_0000_0000;
      return s;
   endfunction

   function automatic longint bump(longint v);
      return (v < CNT_MAX) ? v + 1 : v;
   endfunction

   // Applies one request to the shadow state and returns the response it owes.
   function automatic score_type score_request(request_type r);
      score_type       s;
      longint unsigned ha, hb, ma, mb, na, nb;
      longint          g1, g2, g3, acc, tol;
      s = '0;
      case (r.operation)
         bcmi_pkg::OP_START: begin
            if (have_a && r.class_label == label_a) begin
               open_is_b = 1'b0;
            end else if (have_b && r.class_label == label_b) begin
               open_is_b = 1'b1;
            end else if (!have_a) begin
               have_a = 1'b1; label_a = r.class_label; open_is_b = 1'b0;
            end else if (!have_b) begin
               have_b = 1'b1; label_b = r.class_label; open_is_b = 1'b1;
            end else begin
               // A third label closes the open record and counts nothing.
               rec_open = 1'b0;
               s.status = bcmi_pkg::ST_THIRD;
               return s;
            end
            if (open_is_b) recs_b = bump(recs_b);
            else recs_a = bump(recs_a);
            recs_total = bump(recs_total);
            rec_open = 1'b1;
         end
         bcmi_pkg::OP_SET: begin
            if (!rec_open) begin
               s.status = bcmi_pkg::ST_NO_REC;
            end else if (open_is_b) begin
               if (hits_b_mem[r.bit_index] < recs_b) hits_b_mem[r.bit_index]++;
            end else begin
               if (hits_a_mem[r.bit_index] < recs_a) hits_a_mem[r.bit_index]++;
            end
         end
         bcmi_pkg::OP_QUERY: begin
            if (recs_total == 0) return s;
            na = recs_a; nb = recs_b;
            ha = hits_a_mem[r.bit_index]; hb = hits_b_mem[r.bit_index];
            if (ha > na) ha = na;
            if (hb > nb) hb = nb;
            ma = na - ha; mb = nb - hb;
            s.bit_seen = (ha + hb) != 0;
            s.hits_a   = bcmi_pkg::CNT_W'(ha);
            s.hits_b   = bcmi_pkg::CNT_W'(hb);
            s.misses_a = bcmi_pkg::CNT_W'(ma);
            s.misses_b = bcmi_pkg::CNT_W'(mb);
            g1  = (n_log_n(ha) + n_log_n(ma)) - n_log_n(na);
            g2  = (n_log_n(hb) + n_log_n(mb)) - n_log_n(nb);
            g3  = longint'((na + nb) * log2_fixed(recs_total)) - n_log_n(ha + hb);
            g3  = add_clamped(g3, -n_log_n(ma + mb));
            acc = add_clamped(add_clamped(g1, g2), g3);
            tol = (64'd1 << FRAC) / 100;
            if (acc < 0) begin
               // Rounding noise just below zero reads as zero information.
               if (acc < -tol) s.status = bcmi_pkg::ST_NEG;
               return s;
            end
            s.mutual_info = bcmi_pkg::MI_W'((acc > MI_MAX) ? MI_MAX : acc);
         end
         default: ;
      endcase
      return s;
   endfunction

   function automatic request_type make_request(logic [bcmi_pkg::OP_W-1:0] op,
                                                logic [bcmi_pkg::LABEL_W-1:0] lbl,
                                                logic [bcmi_pkg::INDEX_W-1:0] idx);
      request_type r;
      r.operation = op; r.class_label = lbl; r.bit_index = idx;
      return r;
   endfunction

   // Bit index biased toward a few hot bits so queries see real counts.
   function automatic logic [bcmi_pkg::INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 9) < 7) return bcmi_pkg::INDEX_W'($urandom_range(0, 15));
      return bcmi_pkg::INDEX_W'($urandom_range(0, NUM_BITS - 1));
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 13);
   endfunction

   // Request driver. Each accepted request is scored at the edge where it is
   // taken, so the expectation is queued before its response can appear.
   int send_wait = 0;
   request_type in_flight;

   always @(posedge clock) begin
      logic taken;
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.operation   <= bcmi_pkg::OP_START;
         req_chan.class_label <= '0;
         req_chan.bit_index   <= '0;
         send_wait = 0;
      end else begin
         taken = req_chan.valid && req_chan.ready;
         if (taken) begin
            expected_scores.push_back(score_request(in_flight));
            send_wait = pick_gap();
         end
         if (!req_chan.valid || taken) begin
            if (send_wait == 0 && pending_requests.size() > 0) begin
               in_flight = pending_requests.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.operation   <= in_flight.operation;
               req_chan.class_label <= in_flight.class_label;
               req_chan.bit_index   <= in_flight.bit_index;
            end else begin
               req_chan.valid <= 1'b0;
               if (send_wait > 0) send_wait--;
            end
         end
      end
   end

   // Response monitor with its own stall counter. Once, a long hold-off lets
   // the sender back up behind a finished response.
   int  recv_wait = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin
      score_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            responses_seen++;
            if (expected_scores.size() == 0) begin
               $error("response with nothing expected");
               failures++;
            end else begin
               want = expected_scores.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, rsp_chan.status);
                  failures++;
               end
               if (rsp_chan.bit_seen !== want.bit_seen) begin
                  $error("bit_seen exp %0d got %0d", want.bit_seen, rsp_chan.bit_seen);
                  failures++;
               end
               if (rsp_chan.hits_a !== want.hits_a) begin
                  $error("hits_a exp %0d got %0d", want.hits_a, rsp_chan.hits_a);
                  failures++;
               end
               if (rsp_chan.hits_b !== want.hits_b) begin
                  $error("hits_b exp %0d got %0d", want.hits_b, rsp_chan.hits_b);
                  failures++;
               end
               if (rsp_chan.misses_a !== want.misses_a) begin
                  $error("misses_a exp %0d got %0d", want.misses_a, rsp_chan.misses_a);
                  failures++;
               end
               if (rsp_chan.misses_b !== want.misses_b) begin
                  $error("misses_b exp %0d got %0d", want.misses_b, rsp_chan.misses_b);
                  failures++;
               end
               if (rsp_chan.mutual_info !== want.mutual_info) begin
                  $error("mutual_info exp %0d got %0d", want.mutual_info,
                         rsp_chan.mutual_info);
                  failures++;
               end
            end
            recv_wait = pick_gap();
            if (!long_hold_done && responses_seen >= 200) begin
               recv_wait = 600;
               long_hold_done = 1'b1;
            end
         end
         if (recv_wait > 0) begin
            rsp_chan.ready <= 1'b0;
            recv_wait--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog on total run length.
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("bit_class_mutual_information_core_tb: errors");
         $finish;
      end
   end

   initial begin
      logic [bcmi_pkg::LABEL_W-1:0] lbl_a, lbl_b;
      int                 made;
      int                 nsets;
      label_a = '0; label_b = '0;
      have_a = 1'b0; have_b = 1'b0; open_is_b = 1'b0; rec_open = 1'b0;
      recs_a = 0; recs_b = 0; recs_total = 0;
      foreach (hits_a_mem[i]) begin
         hits_a_mem[i] = 0;
         hits_b_mem[i] = 0;
      end

      // Directed opening: empty query, set bit with no record, unused
      // operation, the label extremes, a third class, repeated hits on one
      // bit and the index extremes.
      lbl_a = 16'hFFFF;
      lbl_b = 16'h0000;
      pending_requests.push_back(make_request(bcmi_pkg::OP_QUERY, 16'h0000, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_SET, 16'h0000, 11'd5));
      pending_requests.push_back(make_request(OP_UNUSED, 16'hFFFF, 11'h7FF));
      pending_requests.push_back(make_request(bcmi_pkg::OP_START, lbl_a, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_SET, 16'h1234, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_SET, 16'h0, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_SET, 16'h0, 11'd2047));
      pending_requests.push_back(make_request(bcmi_pkg::OP_QUERY, 16'h0, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_START, lbl_b, 11'h7FF));
      pending_requests.push_back(make_request(bcmi_pkg::OP_SET, 16'h0, 11'd2047));
      pending_requests.push_back(make_request(bcmi_pkg::OP_QUERY, 16'h0, 11'd2047));
      pending_requests.push_back(make_request(bcmi_pkg::OP_QUERY, 16'h0, 11'd1));
      pending_requests.push_back(make_request(bcmi_pkg::OP_START, 16'h5A5A, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_SET, 16'h0, 11'd3));
      pending_requests.push_back(make_request(bcmi_pkg::OP_START, lbl_a, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_SET, 16'h0, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_QUERY, 16'h0, 11'd0));
      pending_requests.push_back(make_request(bcmi_pkg::OP_QUERY, 16'h0, 11'd2047));
      pending_requests.push_back(make_request(bcmi_pkg::OP_QUERY, 16'hA5A5, 11'd1024));

      // Random records: a start with one of the two known labels and a few
      // set bits, queries sprinkled in, plus some rejected labels and noise.
      made = 0;
      while (made < N_RANDOM) begin
         case ($urandom_range(0, 19))
            0: pending_requests.push_back(make_request(bcmi_pkg::OP_START,
                  bcmi_pkg::LABEL_W'($urandom), bcmi_pkg::INDEX_W'($urandom)));
            1: pending_requests.push_back(make_request(OP_UNUSED,
                  bcmi_pkg::LABEL_W'($urandom), bcmi_pkg::INDEX_W'($urandom)));
            default: begin
               pending_requests.push_back(make_request(bcmi_pkg::OP_START,
                  $urandom_range(0, 1) ? lbl_a : lbl_b, bcmi_pkg::INDEX_W'($urandom)));
               nsets = $urandom_range(0, 6);
               for (int k = 0; k < nsets; k++)
                  pending_requests.push_back(make_request(bcmi_pkg::OP_SET,
                     bcmi_pkg::LABEL_W'($urandom), pick_index()));
               made += nsets;
            end
         endcase
         made++;
         if ($urandom_range(0, 2) == 0) begin
            pending_requests.push_back(make_request(bcmi_pkg::OP_QUERY,
               bcmi_pkg::LABEL_W'($urandom), pick_index()));
            made++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_requests.size() == 0 && !req_chan.valid);
      wait (expected_scores.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (failures == 0 && expected_scores.size() == 0) begin
         $display("bit_class_mutual_information_core_tb: clean");
      end else begin
         $display("bit_class_mutual_information_core_tb: errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/bcmi_pkg.sv
rtl/bcmi_if.sv
rtl/bcmi_term_unit.sv
rtl/bit_class_mutual_information_core.sv
rtl/bcmi_checker.sv
tb/bit_class_mutual_information_core_tb.sv
